FILE: sv/clt_pkg.sv
// shared types, constants and helpers for the collision layer table
// no dependencies; compiled first

package clt_pkg;

  localparam int MAX_LAYERS = 256;
  localparam int ADDR_W     = $clog2(MAX_LAYERS);
  localparam int CNT_W      = $clog2(MAX_LAYERS + 1);

  localparam logic [15:0] NO_LAYER = 16'hFFFF;

  // item kinds
  localparam logic [1:0] KIND_REG  = 2'd0;
  localparam logic [1:0] KIND_PAIR = 2'd1;
  localparam logic [1:0] KIND_RESP = 2'd2;
  localparam logic [1:0] KIND_DOM  = 2'd3;

  // response codes
  localparam logic [1:0] RESP_IGNORE = 2'd0;
  localparam logic [1:0] RESP_BLOCK  = 2'd2;
  localparam logic [1:0] RESP_RSVD   = 2'd3;

  // header layout: domain in bit 7, enable mode in bits 6..5, channel in bits 4..0
  typedef struct packed {
    logic       domain;
    logic [1:0] mode;
    logic [4:0] channel;
  } clt_hdr_t;

  typedef struct packed {
    clt_hdr_t    hdr;
    logic [63:0] resp;
  } clt_entry_t;

  // response of a layer toward a channel, reserved code reads as block
  function automatic logic [1:0] resp_sel(input logic [63:0] resp, input logic [4:0] ch);
    logic [1:0] code;
    code = resp[{ch, 1'b0} +: 2];
    return (code == RESP_RSVD) ? RESP_BLOCK : code;
  endfunction

endpackage

FILE: sv/clt_if.sv
// channel interfaces of the collision layer table: request and result
// no dependencies

interface clt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  object_channel;
  logic [1:0]  enable_mode;
  logic        body_domain;
  logic [63:0] response_codes;
  logic [15:0] layer_a;
  logic [15:0] layer_b;
  logic [4:0]  query_channel;

  modport source (
    output valid, kind, object_channel, enable_mode, body_domain,
           response_codes, layer_a, layer_b, query_channel,
    input  ready
  );
  modport sink (
    input  valid, kind, object_channel, enable_mode, body_domain,
           response_codes, layer_a, layer_b, query_channel,
    output ready
  );
endinterface

interface clt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] layer_index;
  logic [1:0]  interaction;
  logic        domain_out;
  logic [8:0]  layers_in_use;

  modport source (
    output valid, layer_index, interaction, domain_out, layers_in_use,
    input  ready
  );
  modport sink (
    input  valid, layer_index, interaction, domain_out, layers_in_use,
    output ready
  );
endinterface

FILE: sv/clt_mem.sv
// layer store: one write port, one read port with registered read data
// depends on clt_pkg

module clt_mem import clt_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  clt_entry_t        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output clt_entry_t        rdata_o
);

  clt_entry_t mem [MAX_LAYERS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/collision_layer_table.sv
// collision layer table: a new signature is compared against the stored entries in order
// and appended if none matches; a domain or response query reads one layer, a pair query
// two, and a query on a missing layer goes straight to the result; ready rises with result
// valid, so a new request waits until the last result is in the output register; the scan
// uses the single store read port. reset clears the layer count and control state; the store
// is not cleared, entries at or above the count are never used. depends on clt_pkg, clt_if and clt_mem

module collision_layer_table import clt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  clt_in_if.sink      in_i,
  clt_out_if.source   out_o
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_RD_A   = 3'd3;
  localparam logic [2:0] S_RD_B   = 3'd4;
  localparam logic [2:0] S_EVAL   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;     // layers in use
  logic [CNT_W-1:0] ptr_q, ptr_d;     // next entry the scan reads
  logic [ADDR_W-1:0] idx_q, idx_d;    // entry whose data arrives this cycle
  logic             pend_q, pend_d;   // read data in flight for idx_q
  logic             ov_q, ov_d;       // result register holds a transaction

  // captured request
  logic [1:0]  kind_q, kind_d;
  clt_entry_t  sig_q, sig_d;
  logic [15:0] la_q, la_d;
  logic [15:0] lb_q, lb_d;
  logic [4:0]  qch_q, qch_d;
  clt_entry_t  a_q, a_d;              // first layer of a pair query

  // result staging and output register
  logic [15:0] res_idx_q, res_idx_d;
  logic [1:0]  res_int_q, res_int_d;
  logic        res_dom_q, res_dom_d;
  logic [15:0] out_idx_q, out_idx_d;
  logic [1:0]  out_int_q, out_int_d;
  logic        out_dom_q, out_dom_d;
  logic [8:0]  out_cnt_q, out_cnt_d;

  // store port
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  clt_entry_t        rdata;

  logic        in_range;
  logic [1:0]  resp_ab, resp_ba;

  clt_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (sig_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = ov_q;
  assign out_o.layer_index   = out_idx_q;
  assign out_o.interaction   = out_int_q;
  assign out_o.domain_out    = out_dom_q;
  assign out_o.layers_in_use = out_cnt_q;

  // both layers must be present for a pair query, only the first otherwise
  assign in_range = (in_i.layer_a < 16'(cnt_q)) &&
                    ((in_i.kind != KIND_PAIR) || (in_i.layer_b < 16'(cnt_q)));

  // pair lookup: a toward b's channel and b toward a's channel
  assign resp_ab = resp_sel(a_q.resp, rdata.hdr.channel);
  assign resp_ba = resp_sel(rdata.resp, a_q.hdr.channel);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    kind_d    = kind_q;
    sig_d     = sig_q;
    la_d      = la_q;
    lb_d      = lb_q;
    qch_d     = qch_q;
    a_d       = a_q;
    res_idx_d = res_idx_q;
    res_int_d = res_int_q;
    res_dom_d = res_dom_q;
    out_idx_d = out_idx_q;
    out_int_d = out_int_q;
    out_dom_d = out_dom_q;
    out_cnt_d = out_cnt_q;
    we        = 1'b0;
    waddr     = cnt_q[ADDR_W-1:0];
    raddr     = ptr_q[ADDR_W-1:0];

    // result register drains independently of the sequencer
    ov_d = ov_q && !out_o.ready;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d      = in_i.kind;
          sig_d.hdr   = '{domain:  in_i.body_domain,
                          mode:    in_i.enable_mode,
                          channel: in_i.object_channel};
          sig_d.resp  = in_i.response_codes;
          la_d        = in_i.layer_a;
          lb_d        = in_i.layer_b;
          qch_d       = in_i.query_channel;
          res_idx_d   = '0;
          res_int_d   = RESP_IGNORE;
          res_dom_d   = 1'b0;
          if (in_i.kind == KIND_REG) begin
            ptr_d   = '0;
            pend_d  = 1'b0;
            state_d = S_SCAN;
          end else if (!in_range) begin
            // missing layer: ignore for lookups, dynamic for the domain query
            res_dom_d = (in_i.kind == KIND_DOM);
            state_d   = S_DONE;
          end else begin
            state_d = S_RD_A;
          end
        end
      end

      // pipelined scan: issue one read and compare the previous one each cycle
      S_SCAN: begin
        if (pend_q && (rdata == sig_q)) begin
          res_idx_d = 16'(idx_q);
          state_d   = S_DONE;
        end else if (ptr_q < cnt_q) begin
          raddr  = ptr_q[ADDR_W-1:0];
          idx_d  = ptr_q[ADDR_W-1:0];
          ptr_d  = ptr_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_APPEND;
        end
      end

      // no match: take the next free entry, or report a full table
      S_APPEND: begin
        if (cnt_q < CNT_W'(MAX_LAYERS)) begin
          we        = 1'b1;
          waddr     = cnt_q[ADDR_W-1:0];
          res_idx_d = 16'(cnt_q);
          cnt_d     = cnt_q + 1'b1;
        end else begin
          res_idx_d = NO_LAYER;
        end
        state_d = S_DONE;
      end

      S_RD_A: begin
        raddr   = la_q[ADDR_W-1:0];
        state_d = (kind_q == KIND_PAIR) ? S_RD_B : S_EVAL;
      end

      S_RD_B: begin
        raddr   = lb_q[ADDR_W-1:0];
        a_d     = rdata;
        state_d = S_EVAL;
      end

      // read data holds layer b for a pair query, layer a otherwise
      S_EVAL: begin
        case (kind_q)
          KIND_PAIR: res_int_d = (resp_ab < resp_ba) ? resp_ab : resp_ba;
          KIND_RESP: res_int_d = resp_sel(rdata.resp, qch_q);
          KIND_DOM:  res_dom_d = rdata.hdr.domain;
          default:   res_int_d = RESP_IGNORE;
        endcase
        state_d = S_DONE;
      end

      // hand the result over once the output register is free
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          out_idx_d = res_idx_q;
          out_int_d = res_int_q;
          out_dom_d = res_dom_q;
          out_cnt_d = 9'(cnt_q);
          ov_d      = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    kind_q    <= kind_d;
    sig_q     <= sig_d;
    la_q      <= la_d;
    lb_q      <= lb_d;
    qch_q     <= qch_d;
    a_q       <= a_d;
    res_idx_q <= res_idx_d;
    res_int_q <= res_int_d;
    res_dom_q <= res_dom_d;
    out_idx_q <= out_idx_d;
    out_int_q <= out_int_d;
    out_dom_q <= out_dom_d;
    out_cnt_q <= out_cnt_d;
  end

endmodule
